[rtl/box_mean_filter_3x3_clipped_core_macros.svh]
// Assertion macros for the checker of the box mean filter.
`ifndef BOX_MEAN_FILTER_3X3_CLIPPED_CORE_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_CLIPPED_CORE_MACROS_SVH

// Check a property at every rising edge outside reset.
`define BMF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property at every rising edge, reset cycles included.
`define BMF_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bmf_pkg.sv]
// Package: sizes, codes and reciprocal table of the 3x3 clipped box mean filter.
`default_nettype none

package bmf_pkg;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS + 1);  // also holds the drain row
  localparam int DIM_W     = 11;
  localparam int OUT_IDX_W = 10;
  localparam int CFG_IDX_W = 2;

  // Up to nine samples summed; the magnitude of the sum is at most 9 * 2^(SAMPLE_BITS-1).
  localparam int SUM_W       = SAMPLE_BITS + 4;
  localparam int MAG_W       = SAMPLE_BITS + 3;
  localparam int RECIP_SHIFT = MAG_W + 5;
  localparam int RECIP_W     = RECIP_SHIFT - 1;
  localparam int PROD_W      = MAG_W + RECIP_W;

  // Rounded-up reciprocals, exact for every magnitude below 2^MAG_W.
  localparam longint unsigned RECIP4 = (64'd1 << RECIP_SHIFT) / 4;
  localparam longint unsigned RECIP6 = ((64'd1 << RECIP_SHIFT) + 64'd5) / 6;
  localparam longint unsigned RECIP9 = ((64'd1 << RECIP_SHIFT) + 64'd8) / 9;

  localparam int FIFO_AW    = 3;
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    DIV4,
    DIV6,
    DIV9
  } div_sel_t;

  function automatic logic [RECIP_W-1:0] recip(input div_sel_t d);
    case (d)
      DIV4: begin
        return RECIP_W'(RECIP4);
      end
      DIV6: begin
        return RECIP_W'(RECIP6);
      end
      default: begin
        return RECIP_W'(RECIP9);
      end
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/bmf_in_if.sv]
// Interface: input sample channel of the box mean filter.
`default_nettype none

interface bmf_in_if
  import bmf_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

`default_nettype wire

[rtl/bmf_out_if.sv]
// Interface: result channel of the box mean filter.
`default_nettype none

interface bmf_out_if
  import bmf_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic [OUT_IDX_W-1:0]          out_row;
  logic [OUT_IDX_W-1:0]          out_col;
  logic                          last;

  modport source (output valid, output mean, output out_row, output out_col, output last,
                  input ready);
  modport sink   (input valid, input mean, input out_row, input out_col, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/bmf_cfg_if.sv]
// Interface: register write channel of the box mean filter.
`default_nettype none

interface bmf_cfg_if
  import bmf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/box_mean_filter_3x3_clipped_core.sv]
// Top level: 3x3 clipped box mean filter over a raster stream, line buffers in RAM.
//
//   channel  dir  payload                                 beat taken when
//   in_bus   in   op, sample                              valid && ready
//   out_bus  out  mean, out_row, out_col, last            valid && ready
//   cfg_bus  in   index (0 = num_rows, 1 = num_cols), data  valid && ready (ready tied high)
//
// One input beat per cycle while the result queue has room. A taken beat issues the RAM read
// and loads stage 1; its sums then register in stage 2, and its results, after the reciprocal
// multiply, enter the queue, so they are shown on out_bus from then on.
// The line buffer RAM is read once and written at most once per beat, so it sets the one-beat rate.
// Reset clears position, window and queue; the line buffers need no clearing pass.
// in_bus.ready drops only when the 8-entry result queue could overflow with work in flight.
// A write to num_rows or num_cols restarts the frame at row 0, column 0.
`default_nettype none

module box_mean_filter_3x3_clipped_core
  import bmf_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  bmf_in_if.sink    in_bus,
  bmf_out_if.source out_bus,
  bmf_cfg_if.sink   cfg_bus
);

  // Item as it leaves the position logic: flags of the window shape plus the new sample.
  typedef struct packed {
    logic                          drain;
    logic                          has_res;  // row above exists, so results are due
    logic                          emit_a;   // element one column to the left
    logic                          emit_b;   // element in the last column
    logic                          left;     // left neighbor column inside the matrix
    logic                          ut;       // top neighbor row inside the matrix
    logic [OUT_IDX_W-1:0]          row_i;
    logic [COL_W-1:0]              col;
    logic signed [SAMPLE_BITS-1:0] x;
  } s1_t;

  // One pending result: magnitude of the window sum and the divisor to apply.
  typedef struct packed {
    logic                 en;
    logic                 neg;
    logic [MAG_W-1:0]     mag;
    div_sel_t             div;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 last;
  } pend_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean;
    logic [OUT_IDX_W-1:0]          row;
    logic [OUT_IDX_W-1:0]          col;
    logic                          last;
  } result_t;

  function automatic logic signed [SUM_W-1:0] col_sum(
    input logic signed [SAMPLE_BITS-1:0] t_v,
    input logic signed [SAMPLE_BITS-1:0] m_v,
    input logic signed [SAMPLE_BITS-1:0] b_v,
    input logic                          use_t,
    input logic                          use_b
  );
    logic signed [SUM_W-1:0] acc;
    acc = SUM_W'(m_v);
    if (use_t) begin
      acc = acc + SUM_W'(t_v);
    end
    if (use_b) begin
      acc = acc + SUM_W'(b_v);
    end
    return acc;
  endfunction

  // Divide the magnitude by 4, 6 or 9 through its reciprocal, then restore the sign.
  function automatic result_t finish(input pend_t p);
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS-1:0] q;
    result_t                r;
    prod   = PROD_W'(p.mag) * PROD_W'(recip(p.div));
    q      = prod[RECIP_SHIFT +: SAMPLE_BITS];
    r.mean = p.neg ? -q : q;
    r.row  = p.row;
    r.col  = p.col;
    r.last = p.last;
    return r;
  endfunction

  // ---------------------------------------------------------------- configuration
  logic                 cfg_fire;
  logic                 cfg_hit;
  logic [DIM_W-1:0]     dim_lo;
  logic [ROW_W-1:0]     rows_clamped;
  logic [COL_W-1:0]     cols_last_clamped;
  logic [ROW_W-1:0]     rows_r, rows_nxt;
  logic [COL_W-1:0]     cols_last_r, cols_last_nxt;

  assign cfg_bus.ready = 1'b1;
  assign cfg_fire      = cfg_bus.valid && cfg_bus.ready;

  // Hold the clamped sizes: below 2 acts as 2, above the maximum as the maximum.
  assign dim_lo            = (cfg_bus.data < DIM_W'(2)) ? DIM_W'(2) : cfg_bus.data;
  assign rows_clamped      = (int'(dim_lo) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(dim_lo);
  assign cols_last_clamped = (int'(dim_lo) > MAX_COLS) ? COL_W'(MAX_COLS - 1)
                                                       : COL_W'(dim_lo - DIM_W'(1));

  always_comb begin
    rows_nxt      = rows_r;
    cols_last_nxt = cols_last_r;
    cfg_hit       = 1'b0;
    if (cfg_fire) begin
      case (cfg_bus.index)
        CFG_NUM_ROWS: begin
          rows_nxt = rows_clamped;
          cfg_hit  = 1'b1;
        end
        CFG_NUM_COLS: begin
          cols_last_nxt = cols_last_clamped;
          cfg_hit       = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- raster position
  logic             in_fire;
  logic             step;
  logic             drain;
  logic             row_end;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  assign in_fire = in_bus.valid && in_bus.ready;
  assign drain   = (row_r == rows_r);
  assign row_end = (col_r == cols_last_r);
  // Drop a drain beat that arrives inside the frame: no state change, no result.
  assign step    = in_fire && !(in_bus.op && !drain);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_hit) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (step) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = drain ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: line buffer read
  s1_t                           s1_nxt;
  s1_t                           s1_r;
  logic                          s1_v_r;
  logic [2*SAMPLE_BITS-1:0]      ram_rdata;
  logic                          ram_we;
  logic signed [SAMPLE_BITS-1:0] top_v;
  logic signed [SAMPLE_BITS-1:0] mid_v;

  always_comb begin
    s1_nxt.drain   = drain;
    s1_nxt.has_res = (row_r != '0);
    s1_nxt.emit_a  = (col_r != '0);
    s1_nxt.emit_b  = row_end;
    s1_nxt.left    = (col_r > COL_W'(1));
    s1_nxt.ut      = (row_r > ROW_W'(1));
    s1_nxt.row_i   = OUT_IDX_W'(row_r - ROW_W'(1));
    s1_nxt.col     = col_r;
    s1_nxt.x       = drain ? '0 : in_bus.sample;
  end

  // Each entry packs the upper line over the middle line for one column.
  // Consecutive beats hit different columns, so a write lands before the next read of it.
  assign ram_we = s1_v_r && !s1_r.drain;
  assign top_v  = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign mid_v  = ram_rdata[SAMPLE_BITS-1:0];

  bmf_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (MAX_COLS)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_r.col),
    .wdata ({mid_v, s1_r.x}),
    .re    (step),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- window sums
  logic signed [SAMPLE_BITS-1:0] win_r [6];
  logic                          ub;
  logic                          nr3;
  logic signed [SUM_W-1:0]       s0, s1, s2;
  logic signed [SUM_W-1:0]       sum_a, sum_b;
  pend_t                         pa_nxt, pb_nxt;

  always_comb begin
    ub    = !s1_r.drain;
    nr3   = s1_r.ut && ub;
    s0    = col_sum(top_v, mid_v, s1_r.x, s1_r.ut, ub);
    s1    = col_sum(win_r[0], win_r[1], win_r[2], s1_r.ut, ub);
    s2    = col_sum(win_r[3], win_r[4], win_r[5], s1_r.ut, ub);
    sum_b = s1 + s0;
    sum_a = s1_r.left ? sum_b + s2 : sum_b;

    pa_nxt.en   = s1_r.has_res && s1_r.emit_a;
    pa_nxt.neg  = sum_a[SUM_W-1];
    pa_nxt.mag  = sum_a[SUM_W-1] ? MAG_W'(-sum_a) : MAG_W'(sum_a);
    pa_nxt.div  = (nr3 && s1_r.left) ? DIV9 : ((nr3 || s1_r.left) ? DIV6 : DIV4);
    pa_nxt.row  = s1_r.row_i;
    pa_nxt.col  = OUT_IDX_W'(s1_r.col - COL_W'(1));
    pa_nxt.last = 1'b0;

    pb_nxt.en   = s1_r.has_res && s1_r.emit_b;
    pb_nxt.neg  = sum_b[SUM_W-1];
    pb_nxt.mag  = sum_b[SUM_W-1] ? MAG_W'(-sum_b) : MAG_W'(sum_b);
    pb_nxt.div  = nr3 ? DIV6 : DIV4;
    pb_nxt.row  = s1_r.row_i;
    pb_nxt.col  = OUT_IDX_W'(s1_r.col);
    pb_nxt.last = s1_r.drain;
  end

  // ---------------------------------------------------------------- stage 2: divide, queue
  pend_t   s2_a_r, s2_b_r;
  logic    s2_v_r;
  result_t res_a, res_b;
  logic    push_a, push_b, pop;
  result_t fifo_r [FIFO_DEPTH];
  result_t head;
  logic [FIFO_AW-1:0] wp_r, wp_nxt, wp_b, rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign res_a  = finish(s2_a_r);
  assign res_b  = finish(s2_b_r);
  assign push_a = s2_v_r && s2_a_r.en;
  assign push_b = s2_v_r && s2_b_r.en;
  assign pop    = out_bus.valid && out_bus.ready;
  assign wp_b   = wp_r + FIFO_AW'(push_a);
  assign wp_nxt = wp_b + FIFO_AW'(push_b);
  assign rp_nxt = rp_r + FIFO_AW'(pop);
  assign cnt_nxt = cnt_r + FIFO_CW'(push_a) + FIFO_CW'(push_b) - FIFO_CW'(pop);

  // Take a beat only while the queue has room for two results of every beat in flight.
  assign in_bus.ready = (int'(cnt_r) + 2 * (int'(s1_v_r) + int'(s2_v_r)) + 2) <= FIFO_DEPTH;

  assign head            = fifo_r[rp_r];
  assign out_bus.valid   = (cnt_r != '0);
  assign out_bus.mean    = head.mean;
  assign out_bus.out_row = head.row;
  assign out_bus.out_col = head.col;
  assign out_bus.last    = head.last;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= ROW_W'(2);
      cols_last_r <= COL_W'(1);
      row_r       <= '0;
      col_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      rows_r      <= rows_nxt;
      cols_last_r <= cols_last_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      s1_v_r      <= step;
      s2_v_r      <= s1_v_r;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      // Advance the window by one column for every beat that passes stage 1.
      if (s1_v_r) begin
        win_r[3] <= win_r[0];
        win_r[4] <= win_r[1];
        win_r[5] <= win_r[2];
        win_r[0] <= top_v;
        win_r[1] <= mid_v;
        win_r[2] <= s1_r.x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_r <= s1_nxt;
    end
    if (s1_v_r) begin
      s2_a_r <= pa_nxt;
      s2_b_r <= pb_nxt;
    end
    // Queue the left element first, then the last-column element.
    if (push_a) begin
      fifo_r[wp_r] <= res_a;
    end
    if (push_b) begin
      fifo_r[wp_b] <= res_b;
    end
  end

endmodule

`default_nettype wire

[rtl/bmf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none

module bmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire             clk,
  input  wire             we,
  input  wire [AW-1:0]    waddr,
  input  wire [WIDTH-1:0] wdata,
  input  wire             re,
  input  wire [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/bmf_checker.sv]
// Checker: port-level properties of the box mean filter, bound to the top level.
`default_nettype none
`include "box_mean_filter_3x3_clipped_core_macros.svh"

module bmf_checker
  import bmf_pkg::*;
(
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [SAMPLE_BITS-1:0] out_mean,
  input wire [OUT_IDX_W-1:0]   out_row,
  input wire [OUT_IDX_W-1:0]   out_col,
  input wire                   out_last
);

  // Reset empties the result queue.
  `BMF_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid, "result beat right after reset")

  // A stalled result beat holds its payload.
  `BMF_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable({out_mean, out_row, out_col, out_last}), "stalled result changed")

  // The final result of a frame sits in the last column, never in column zero.
  `BMF_ASSERT(a_last_col, clk, rst_n, out_valid && out_last |-> out_col != '0, "last beat in column zero")

  // A result appears on an empty port only after the beat that caused it has passed stage 1, stage 2 and the queue.
  `BMF_ASSERT(a_latency, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 3), "result without input beat")

endmodule

bind box_mean_filter_3x3_clipped_core bmf_checker u_bmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_mean  (out_bus.mean),
  .out_row   (out_bus.out_row),
  .out_col   (out_bus.out_col),
  .out_last  (out_bus.last)
);

`default_nettype wire
